// ===== src/bdc_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; the dabble step, the converter and the testbench depend on it.
package bdc_pkg;

    // Fixed width of the incoming value field.
    localparam int FIELD_WIDTH = 32;

    // Width of one emitted ASCII character field.
    localparam int CHAR_WIDTH = 6;

    // ASCII code of the character '0'.
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 6'd48;

    // Threshold and correction used by the shift-and-add-3 step.
    localparam logic [3:0] BCD_ADJUST_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJUST_ADD = 4'd3;

    // Payload of one conversion request.
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] value;
    } operand_payload_t;

    // Payload of one emitted digit.
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] digit_char;
        logic                  last;
    } digit_payload_t;

endpackage

// ===== src/bdc_stream_if.sv =====
// Valid/ready stream channel carrying one payload per request.
// The payload type is a parameter; this file depends on no other file.
interface bdc_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== src/bdc_dabble_step.sv =====
// One shift-and-add-3 iteration over all BCD digits of the accumulator.
// Depends on bdc_pkg for the correction constants.
module bdc_dabble_step #(
    parameter int NUM_DIGITS = 10
) (
    input  logic [NUM_DIGITS-1:0][3:0] bcd,
    input  logic                       shift_bit,
    output logic [NUM_DIGITS-1:0][3:0] bcd_next
);

    logic [NUM_DIGITS-1:0][3:0] corrected;

    // Add three to every digit of five or more, so the shift carries properly.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd[i] >= bdc_pkg::BCD_ADJUST_MIN)
            begin
                corrected[i] = bcd[i] + bdc_pkg::BCD_ADJUST_ADD;
            end
            else
            begin
                corrected[i] = bcd[i];
            end
        end
    end

    // Shift the corrected digits left by one and bring in the next binary bit.
    assign bcd_next = {corrected[NUM_DIGITS-1:0]} << 1 | {{(NUM_DIGITS*4-1){1'b0}}, shift_bit};

endmodule

// ===== src/binary_to_decimal_ascii.sv =====
// Converts an unsigned binary value to its decimal digits as ASCII characters,
// most significant digit first, with leading zeros suppressed and last set on
// the final digit; zero gives the single character '0'. Only the low
// VALUE_WIDTH bits of the 32-bit value take part. A request is first loaded,
// then each value bit (min(VALUE_WIDTH, 32), 32 by default) passes through
// the shared shift-and-add-3 step, then each BCD digit position (10 by
// default) is visited while leading zeros are skipped and digits are emitted;
// emission waits while the output register is full and not taken.
// The operand channel is ready only while no conversion is running; the final
// digit sits in an output register, so the next request can load meanwhile.
module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    bdc_stream_if.sink   operand,
    bdc_stream_if.source digits
);

    // Number of decimal digits of the largest value of a given bit width.
    function automatic int digit_count(input int width);
        longint unsigned v;
        int              n;
        v = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
        n = 0;
        for (int i = 0; i < 20; i++)
        begin
            if (v != 0)
            begin
                n = n + 1;
                v = v / 64'd10;
            end
        end
        return n;
    endfunction

    localparam int EFF_WIDTH  = (VALUE_WIDTH < bdc_pkg::FIELD_WIDTH) ?
                                VALUE_WIDTH : bdc_pkg::FIELD_WIDTH;
    localparam int NUM_DIGITS = digit_count(EFF_WIDTH);
    localparam int CNT_W      = $clog2(EFF_WIDTH);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    state_t                     state_reg;
    logic [EFF_WIDTH-1:0]       bin_reg;
    logic [NUM_DIGITS-1:0][3:0] bcd_reg;
    logic [NUM_DIGITS-1:0][3:0] bcd_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic                       started_reg;
    logic                       out_valid_reg;
    bdc_pkg::digit_payload_t    out_payload_reg;

    logic [3:0] cur_digit;
    logic       emit_now;
    logic       out_free;
    logic       load_out;

    // Shared conversion step, fed by the top bit of the binary shift register.
    bdc_dabble_step #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_step (
        .bcd       (bcd_reg),
        .shift_bit (bin_reg[EFF_WIDTH-1]),
        .bcd_next  (bcd_next)
    );

    // Digit under the emit pointer, and whether it is printed or skipped.
    assign cur_digit = bcd_reg[idx_reg];
    assign emit_now  = started_reg || (cur_digit != 4'd0) || (idx_reg == '0);
    assign out_free  = !out_valid_reg || digits.ready;
    assign load_out  = (state_reg == ST_EMIT) && emit_now && out_free;

    assign operand.ready  = (state_reg == ST_IDLE);
    assign digits.valid   = out_valid_reg;
    assign digits.payload = out_payload_reg;

    // Sequencer: load, iterate the shared step, then walk the digits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            bin_reg         <= '0;
            bcd_reg         <= '0;
            cnt_reg         <= '0;
            idx_reg         <= '0;
            started_reg     <= 1'b0;
            out_payload_reg <= '0;
        end
        else
        begin
            // Output register fills with a new digit, or empties once taken.
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (digits.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (operand.valid)
                    begin
                        bin_reg   <= operand.payload.value[EFF_WIDTH-1:0];
                        bcd_reg   <= '0;
                        cnt_reg   <= CNT_W'(EFF_WIDTH - 1);
                        state_reg <= ST_CONVERT;
                    end
                end

                ST_CONVERT:
                begin
                    bcd_reg <= bcd_next;
                    bin_reg <= bin_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        idx_reg     <= IDX_W'(NUM_DIGITS - 1);
                        started_reg <= 1'b0;
                        state_reg   <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (!emit_now)
                    begin
                        // Leading zero: step past it without output.
                        idx_reg <= idx_reg - 1'b1;
                    end
                    else if (out_free)
                    begin
                        out_payload_reg.digit_char <= bdc_pkg::CHAR_ZERO +
                                                      {2'b00, cur_digit};
                        out_payload_reg.last       <= (idx_reg == '0);
                        started_reg                <= 1'b1;
                        if (idx_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - 1'b1;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/binary_to_decimal_ascii_tb.sv =====
// Self-checking testbench for binary_to_decimal_ascii: drives conversion requests,
// predicts the ASCII digit stream of each value and compares every emitted digit.
// Depends on bdc_pkg, bdc_stream_if and the binary_to_decimal_ascii RTL.
module binary_to_decimal_ascii_tb;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS = 10;
    localparam int RADIX = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_REQUESTS = 500;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [63:0] VALUE_MASK =
        (VALUE_WIDTH >= bdc_pkg::FIELD_WIDTH) ? 64'hFFFF_FFFF :
                                                ((64'd1 << VALUE_WIDTH) - 64'd1);

    // One queued conversion request; drain_first holds it back until all digits are out.
    typedef struct {
        logic [bdc_pkg::FIELD_WIDTH-1:0] value;
        bit                              drain_first;
    } conversion_request_t;

    // Ready patterns of the digit receiver.
    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_SPARSE
    } sink_mode_t;

    logic clk;
    logic rst_n;

    bdc_stream_if #(.payload_t(bdc_pkg::operand_payload_t)) operand_ch ();
    bdc_stream_if #(.payload_t(bdc_pkg::digit_payload_t))   digit_ch ();

    conversion_request_t     pending_requests[$];
    bdc_pkg::digit_payload_t expected_digits[$];

    int         error_count;
    bit         operand_taken;
    int         gap_left;
    int         burst_left;
    sink_mode_t sink_mode;
    int         sink_phase_left;
    int         idle_cycles;

    binary_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .operand(operand_ch),
        .digits (digit_ch)
    );

    // Free-running clock, period 4.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Appends the decimal digits of one value, most significant first, to the expected queue.
    function automatic void predict_digits(input logic [bdc_pkg::FIELD_WIDTH-1:0] value);
        logic [63:0]             remaining;
        bdc_pkg::digit_payload_t reversed[MAX_DIGITS];
        int                      count;
        begin
            remaining = {32'd0, value} & VALUE_MASK;
            count = 0;
            // Zero still produces one digit.
            do
            begin
                reversed[count].digit_char = bdc_pkg::CHAR_ZERO +
                    bdc_pkg::CHAR_WIDTH'(remaining % RADIX);
                reversed[count].last = 1'b0;
                count++;
                remaining = remaining / RADIX;
            end
            while (remaining != 0 && count < MAX_DIGITS);
            reversed[0].last = 1'b1;
            for (int k = count - 1; k >= 0; k--)
            begin
                expected_digits.push_back(reversed[k]);
            end
        end
    endfunction

    function automatic void queue_request(input logic [bdc_pkg::FIELD_WIDTH-1:0] value,
                                          input bit drain);
        conversion_request_t req;
        begin
            req.value = value;
            req.drain_first = drain;
            pending_requests.push_back(req);
        end
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!operand_ch.valid || operand_taken)
            begin
                if (pending_requests.size() == 0 || gap_left != 0 ||
                    (pending_requests[0].drain_first && expected_digits.size() != 0))
                begin
                    operand_ch.valid <= 1'b0;
                    if (gap_left != 0)
                    begin
                        gap_left--;
                    end
                end
                else
                begin
                    operand_ch.valid <= 1'b1;
                    operand_ch.payload.value <= pending_requests[0].value;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 8);
                        // Half of the bursts run back to back with no gap.
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 50);
                    end
                end
            end
        end
    end

    // Digit receiver: ready follows a pattern that is picked anew at random after each phase of random length.
    always @(negedge clk)
    begin
        if (sink_phase_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            sink_phase_left = $urandom_range(50, 300);
        end
        else
        begin
            sink_phase_left--;
        end
        case (sink_mode)
            SINK_ALWAYS: digit_ch.ready <= 1'b1;
            SINK_RANDOM: digit_ch.ready <= ($urandom_range(0, 1) == 1);
            default:     digit_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Accepted requests: predict their digits and retire them from the pending queue.
    always @(posedge clk)
    begin
        operand_taken <= operand_ch.valid && operand_ch.ready;
        if (rst_n && operand_ch.valid && operand_ch.ready)
        begin
            predict_digits(operand_ch.payload.value);
            if (pending_requests.size() != 0)
            begin
                void'(pending_requests.pop_front());
            end
        end
    end

    // Accepted digits: compare against the oldest expectation.
    always @(posedge clk)
    begin
        bdc_pkg::digit_payload_t want;
        if (rst_n && digit_ch.valid && digit_ch.ready)
        begin
            if (expected_digits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digit char=%0d last=%0b",
                    digit_ch.payload.digit_char, digit_ch.payload.last));
            end
            else
            begin
                want = expected_digits.pop_front();
                if (digit_ch.payload.digit_char !== want.digit_char)
                begin
                    report_mismatch($sformatf("digit_char got %0d want %0d",
                        digit_ch.payload.digit_char, want.digit_char));
                end
                if (digit_ch.payload.last !== want.last)
                begin
                    report_mismatch($sformatf("last got %0b want %0b",
                        digit_ch.payload.last, want.last));
                end
            end
        end
    end

    // Watchdog: too many cycles without any handshake ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (operand_ch.valid && operand_ch.ready) ||
            (digit_ch.valid && digit_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [bdc_pkg::FIELD_WIDTH-1:0] value;
        logic [bdc_pkg::FIELD_WIDTH-1:0] power;
        int                              pick;

        error_count = 0;
        gap_left = 0;
        burst_left = 1;
        sink_mode = SINK_ALWAYS;
        sink_phase_left = 0;
        idle_cycles = 0;
        operand_taken = 1'b0;
        rst_n = 1'b0;
        operand_ch.valid = 1'b0;
        operand_ch.payload = '0;
        digit_ch.ready = 1'b0;

        // Directed values: zero, single digits, decade edges and the field extremes.
        queue_request(32'd0, 1'b0);
        queue_request(32'd1, 1'b0);
        queue_request(32'd9, 1'b0);
        queue_request(32'd10, 1'b0);
        queue_request(32'd99, 1'b0);
        queue_request(32'd100, 1'b0);
        queue_request(32'd0, 1'b0);
        queue_request(32'd999_999_999, 1'b0);
        queue_request(32'd1_000_000_000, 1'b0);
        queue_request(32'd1_234_567_890, 1'b0);
        queue_request(32'hFFFF_FFFF, 1'b0);
        queue_request(32'hFFFF_FFFE, 1'b0);
        queue_request(32'h8000_0000, 1'b0);
        queue_request(32'h7FFF_FFFF, 1'b0);
        queue_request(32'hAAAA_AAAA, 1'b0);
        queue_request(32'h5555_5555, 1'b0);
        queue_request(32'h0000_000F, 1'b0);
        queue_request(32'd4_000_000_000, 1'b0);

        // Random values spread over all magnitudes; the first one waits for a full drain.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // A power of ten or one below it.
                power = 32'd1;
                repeat ($urandom_range(0, 9)) power = power * RADIX;
                value = power - $urandom_range(0, 1);
            end
            else if (pick == 1)
            begin
                value = $urandom_range(0, 9);
            end
            else
            begin
                value = $urandom >> $urandom_range(0, 31);
            end
            queue_request(value, (i == 0) || ($urandom_range(0, 49) == 0));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || operand_ch.valid || expected_digits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/bdc_pkg.sv
src/bdc_stream_if.sv
src/bdc_dabble_step.sv
src/binary_to_decimal_ascii.sv
verif/binary_to_decimal_ascii_tb.sv
